FILE: sv/lps_pkg.sv
// Package for the LED pattern sequencer: item kinds, stream widths and
// default sizes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lps_pkg;

  // Default sizes for the top-level parameters
  localparam int DEF_NUM_SEQUENCES = 16;
  localparam int DEF_MAX_FRAMES    = 64;
  localparam int DEF_DURATION_BITS = 16;

  // Stream widths
  localparam int S_TDATA_W = 40;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 8;

  // Input item kinds carried on s_tuser
  typedef enum logic [2:0] {
    KIND_TICK     = 3'd0,
    KIND_START    = 3'd1,
    KIND_STOP     = 3'd2,
    KIND_WR_FRAME = 3'd3,
    KIND_WR_DESC  = 3'd4
  } kind_t;

endpackage

`default_nettype wire

FILE: sv/lps_ram.sv
// Generic simple dual-port RAM for the LED pattern sequencer: one write port,
// one read port with registered read data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, hold data when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/led_pattern_sequencer.sv
// LED pattern sequencer: one result beat per input beat, registered on m_tdata
// through stage B and then the output register. Stage B holds one beat while the
// frame and descriptor memory reads complete ahead of the playback state update,
// so a new input beat is taken only once stage B has emptied. Reset (rst,
// synchronous) clears playback state, the invert bit, the output handshake and
// the descriptor valid bits; the frame store is not cleared and holds unknown
// data until written. Depends on lps_pkg and lps_ram.
`timescale 1ns / 1ps
`default_nettype none

module led_pattern_sequencer #(
  parameter int NUM_SEQUENCES = lps_pkg::DEF_NUM_SEQUENCES,
  parameter int MAX_FRAMES    = lps_pkg::DEF_MAX_FRAMES,
  parameter int DURATION_BITS = lps_pkg::DEF_DURATION_BITS
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // Configuration: invert_output
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_wdata,
  // Input stream
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  // s_tdata from bit 0: sequence_id[4], frame_index[6], frame_level[1],
  // frame_duration[16], sequence_length[7], loop_flag[1], zero pad[5]
  input  wire logic [lps_pkg::S_TDATA_W-1:0] s_tdata,
  // s_tuser: kind[3]
  input  wire logic [lps_pkg::S_TUSER_W-1:0] s_tuser,
  // Output stream
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // m_tdata from bit 0: led_out[1], running[1], current_frame[6]
  output logic      [lps_pkg::M_TDATA_W-1:0] m_tdata
);

  import lps_pkg::*;

  localparam int SEQ_W   = (NUM_SEQUENCES > 1) ? $clog2(NUM_SEQUENCES) : 1;
  localparam int FP_W    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int LEN_W   = $clog2(MAX_FRAMES + 1);
  localparam int EL_W    = DURATION_BITS + 1;
  localparam int DEPTH   = NUM_SEQUENCES * MAX_FRAMES;
  localparam int FADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FRAME_W = DURATION_BITS + 1;
  localparam int DESC_W  = LEN_W + 1;

  // Input fields
  logic [3:0]  sequence_id;
  logic [5:0]  frame_index;
  logic        frame_level;
  logic [15:0] frame_duration;
  logic [6:0]  sequence_length;
  logic        loop_flag;

  assign sequence_id     = s_tdata[3:0];
  assign frame_index     = s_tdata[9:4];
  assign frame_level     = s_tdata[10];
  assign frame_duration  = s_tdata[26:11];
  assign sequence_length = s_tdata[33:27];
  assign loop_flag       = s_tdata[34];

  // Playback state
  logic              invert_output;
  logic              is_running;
  logic [SEQ_W-1:0]  active_sequence;
  logic [FP_W-1:0]   frame_pointer;
  logic [EL_W-1:0]   elapsed_ticks;
  logic              led_level;
  logic [NUM_SEQUENCES-1:0] desc_valid;

  // Stage B: item whose memory reads are in flight
  logic              b_valid;
  logic [2:0]        b_kind;
  logic              b_id_ok;
  logic [SEQ_W-1:0]  b_id;
  logic              b_desc_valid;

  logic s_acc;
  logic b_fire;

  assign s_tready = !b_valid;
  assign s_acc    = s_tvalid && s_tready;
  assign b_fire   = b_valid && (!m_tvalid || m_tready);

  // Decode the incoming beat
  logic              id_ok;
  logic              fidx_ok;
  logic [SEQ_W-1:0]  id_idx;
  logic [LEN_W-1:0]  len_clip;

  assign id_ok    = 32'(sequence_id) < 32'(NUM_SEQUENCES);
  assign fidx_ok  = 32'(frame_index) < 32'(MAX_FRAMES);
  assign id_idx   = SEQ_W'(sequence_id);
  assign len_clip = (32'(sequence_length) > 32'(MAX_FRAMES)) ? LEN_W'(MAX_FRAMES)
                                                              : LEN_W'(sequence_length);

  // Frame store
  logic               frm_we;
  logic [FADDR_W-1:0] frm_waddr;
  logic [FRAME_W-1:0] frm_wdata;
  logic               frm_re;
  logic [FADDR_W-1:0] frm_raddr;
  logic [FRAME_W-1:0] frm_rdata;

  assign frm_we    = s_acc && (s_tuser == KIND_WR_FRAME) && id_ok && fidx_ok;
  assign frm_waddr = FADDR_W'(32'(sequence_id) * 32'(MAX_FRAMES) + 32'(frame_index));
  assign frm_wdata = {DURATION_BITS'(frame_duration), frame_level};
  assign frm_re    = s_acc && (s_tuser == KIND_TICK);
  assign frm_raddr = FADDR_W'(32'(active_sequence) * 32'(MAX_FRAMES) + 32'(frame_pointer));

  lps_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (DEPTH),
    .ADDR_W(FADDR_W)
  ) u_frame_ram (
    .clk  (clk),
    .we   (frm_we),
    .waddr(frm_waddr),
    .wdata(frm_wdata),
    .re   (frm_re),
    .raddr(frm_raddr),
    .rdata(frm_rdata)
  );

  // Sequence descriptor store: length and loop flag
  logic              dsc_we;
  logic              dsc_re;
  logic [SEQ_W-1:0]  dsc_raddr;
  logic [DESC_W-1:0] dsc_rdata;

  assign dsc_we    = s_acc && (s_tuser == KIND_WR_DESC) && id_ok;
  assign dsc_re    = s_acc && ((s_tuser == KIND_TICK) || (s_tuser == KIND_START));
  assign dsc_raddr = (s_tuser == KIND_START) ? id_idx : active_sequence;

  lps_ram #(
    .WIDTH (DESC_W),
    .DEPTH (NUM_SEQUENCES),
    .ADDR_W(SEQ_W)
  ) u_desc_ram (
    .clk  (clk),
    .we   (dsc_we),
    .waddr(id_idx),
    .wdata({loop_flag, len_clip}),
    .re   (dsc_re),
    .raddr(dsc_raddr),
    .rdata(dsc_rdata)
  );

  // Mark descriptors written since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      desc_valid <= '0;
    end else if (dsc_we) begin
      desc_valid[id_idx] <= 1'b1;
    end
  end

  // Capture the beat into stage B
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (s_acc) begin
      b_valid <= 1'b1;
    end else if (b_fire) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      b_kind       <= s_tuser;
      b_id_ok      <= id_ok;
      b_id         <= id_idx;
      b_desc_valid <= desc_valid[dsc_raddr];
    end
  end

  // Stage B: read data and next playback state
  logic [LEN_W-1:0]         rd_len;
  logic                     rd_loop;
  logic                     rd_level;
  logic [DURATION_BITS-1:0] rd_dur;
  logic [EL_W-1:0]          elapsed_inc;

  assign rd_len      = b_desc_valid ? dsc_rdata[LEN_W-1:0] : '0;
  assign rd_loop     = b_desc_valid && dsc_rdata[LEN_W];
  assign rd_level    = frm_rdata[0];
  assign rd_dur      = frm_rdata[FRAME_W-1:1];
  assign elapsed_inc = (elapsed_ticks != '1) ? elapsed_ticks + EL_W'(1) : elapsed_ticks;

  logic              running_next;
  logic [SEQ_W-1:0]  active_next;
  logic [FP_W-1:0]   frame_pointer_next;
  logic [EL_W-1:0]   elapsed_next;
  logic              led_level_next;

  always_comb begin
    running_next       = is_running;
    active_next        = active_sequence;
    frame_pointer_next = frame_pointer;
    elapsed_next       = elapsed_ticks;
    led_level_next     = led_level;
    case (b_kind)
      KIND_TICK: begin
        if (is_running) begin
          if (rd_len == '0) begin
            running_next = 1'b0;
          end else begin
            elapsed_next = elapsed_inc;
            if (elapsed_inc <= EL_W'(rd_dur)) begin
              led_level_next = rd_level;
            end else if (32'(frame_pointer) + 32'd1 < 32'(rd_len)) begin
              frame_pointer_next = frame_pointer + FP_W'(1);
              elapsed_next       = '0;
            end else if (rd_loop) begin
              frame_pointer_next = '0;
              elapsed_next       = '0;
            end else begin
              running_next = 1'b0;
            end
          end
        end
      end
      KIND_START: begin
        elapsed_next       = '0;
        frame_pointer_next = '0;
        if (b_id_ok && (rd_len != '0)) begin
          running_next = 1'b1;
          active_next  = b_id;
        end else begin
          running_next = 1'b0;
        end
      end
      KIND_STOP: begin
        running_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Commit playback state when the result beat is produced
  always_ff @(posedge clk) begin
    if (rst) begin
      is_running      <= 1'b0;
      active_sequence <= '0;
      frame_pointer   <= '0;
      elapsed_ticks   <= '0;
      led_level       <= 1'b0;
    end else if (b_fire) begin
      is_running      <= running_next;
      active_sequence <= active_next;
      frame_pointer   <= frame_pointer_next;
      elapsed_ticks   <= elapsed_next;
      led_level       <= led_level_next;
    end
  end

  // Invert register
  always_ff @(posedge clk) begin
    if (rst) begin
      invert_output <= 1'b0;
    end else if (cfg_we) begin
      invert_output <= cfg_wdata;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (b_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire) begin
      m_tdata <= {6'(frame_pointer_next), running_next, led_level_next ^ invert_output};
    end
  end

endmodule

`default_nettype wire
